@@ hw/rtl/vsfr_pkg.sv @@
// Package for the video slice frame reassembler: header and result word types,
// status codes, default sizes and the wraparound frame id compare.
// Depends on nothing; imported by video_slice_frame_reassembler.
package vsfr_pkg;

	localparam int WINDOW_SLOTS_DEF = 8;
	localparam int MAX_SLICES_DEF   = 64;
	localparam int SLICE_BYTES_DEF  = 1024;

	localparam logic [16:0] SUM_MAX = 17'h1FFFF;
	localparam logic [3:0]  DROP_MAX = 4'd15;

	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_STALE     = 3'd1,
		ST_NO_SLOT   = 3'd2,
		ST_BAD_INDEX = 3'd3,
		ST_DUPLICATE = 3'd4
	} status_t;

	typedef struct packed {
		logic [31:0] frame_id;
		logic [5:0]  slice_index;
		logic [6:0]  slice_count;
		logic [10:0] payload_len;
		logic [31:0] timestamp;
		logic [15:0] frame_flags;
	} slice_hdr_t;

	typedef struct packed {
		status_t     status;
		logic [2:0]  slot;
		logic [18:0] write_offset;
		logic        complete;
		logic [31:0] done_frame_id;
		logic [31:0] done_timestamp;
		logic [15:0] done_flags;
		logic [16:0] done_length;
		logic [3:0]  dropped_count;
	} slice_res_t;

	// True when frame id a is newer than b under 32-bit wraparound.
	function automatic logic id_after(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return (d != 32'd0) && !d[31];
	endfunction

endpackage

@@ hw/rtl/video_slice_frame_reassembler.sv @@
// Video slice frame reassembler: files slice headers into a window of pending frames.
// A header accepted into the input register (hdr_s1, v_s1) moves on to the result register,
// whose word is then shown on res, marked by strobe.
// Throughput is one header per cycle; the slot table updates in the processing stage,
// so busy stays low and the next header always sees the table it needs.
// Reset clears slot occupancy and the delivery history; the receiver cannot stall.
module video_slice_frame_reassembler
	import vsfr_pkg::*;
#(
	parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF,
	parameter int MAX_SLICES   = MAX_SLICES_DEF,
	parameter int SLICE_BYTES  = SLICE_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  slice_hdr_t hdr,
	output logic       strobe,
	output slice_res_t res
);

	localparam int SLOT_W   = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam int DROP_RAW = $clog2(WINDOW_SLOTS + 1);
	localparam int DROP_W   = (DROP_RAW < 4) ? 4 : DROP_RAW;

	// Input register. Since busy is held low, no header is ever refused.
	slice_hdr_t hdr_s1;
	logic       v_s1;

	// Result register.
	slice_res_t res_s2;
	logic       strobe_s2;

	// Slot table. Only the busy bits are reset; every other field is written when
	// a slot is allocated and is read only while that slot is busy.
	logic [WINDOW_SLOTS-1:0] busy_q;
	logic [31:0]             frame_q [WINDOW_SLOTS];
	logic [31:0]             time_q  [WINDOW_SLOTS];
	logic [15:0]             flags_q [WINDOW_SLOTS];
	logic [6:0]              total_q [WINDOW_SLOTS];
	logic [6:0]              recv_q  [WINDOW_SLOTS];
	logic [MAX_SLICES-1:0]   seen_q  [WINDOW_SLOTS];
	logic [16:0]             sum_q   [WINDOW_SLOTS];
	logic [31:0]             last_q;
	logic                    dlv_once_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			hdr_s1 <= hdr;
		end
	end

	// Lookup. after_m[i][j] says slot i holds a newer frame than slot j; the
	// pairwise compares run side by side, so the oldest-slot scan below only
	// walks a narrow index through the slots in order, keeping the first slot
	// among equals exactly as a sequential scan would.
	logic                    stale;
	logic [WINDOW_SLOTS-1:0] hit_v;
	logic                    found_hit, free_hit, old_hit;
	logic [SLOT_W-1:0]       found_idx, free_idx, old_idx, sel;
	logic                    after_m [WINDOW_SLOTS][WINDOW_SLOTS];

	assign stale = dlv_once_q && !id_after(hdr_s1.frame_id, last_q);

	always_comb begin
		for (int i = 0; i < WINDOW_SLOTS; i++) begin
			hit_v[i] = busy_q[i] && (frame_q[i] == hdr_s1.frame_id);
			for (int j = 0; j < WINDOW_SLOTS; j++) begin
				after_m[i][j] = id_after(frame_q[i], frame_q[j]);
			end
		end
	end

	always_comb begin
		found_hit = 1'b0;
		found_idx = '0;
		free_hit  = 1'b0;
		free_idx  = '0;
		old_hit   = 1'b0;
		old_idx   = '0;
		for (int k = 0; k < WINDOW_SLOTS; k++) begin
			if (hit_v[k] && !found_hit) begin
				found_hit = 1'b1;
				found_idx = SLOT_W'(k);
			end
			if (!busy_q[k] && !free_hit) begin
				free_hit = 1'b1;
				free_idx = SLOT_W'(k);
			end
			if (busy_q[k] && (!old_hit || after_m[old_idx][k])) begin
				old_hit = 1'b1;
				old_idx = SLOT_W'(k);
			end
		end
	end

	// Slot choice. A full window evicts its oldest frame only for a newer one.
	logic newer_than_old, evict, no_slot, alloc;

	assign newer_than_old = old_hit && id_after(hdr_s1.frame_id, frame_q[old_idx]);
	assign evict   = !found_hit && !free_hit && newer_than_old;
	assign no_slot = !found_hit && !free_hit && !newer_than_old;
	assign alloc   = v_s1 && !stale && !found_hit && !no_slot;
	assign sel     = found_hit ? found_idx : (free_hit ? free_idx : old_idx);

	// Slot contents as seen by this slice: a fresh allocation starts empty.
	logic [6:0]            eff_total, eff_recv, new_recv;
	logic [MAX_SLICES-1:0] eff_seen, seen_bit;
	logic [16:0]           eff_sum, new_sum;
	logic [31:0]           eff_time;
	logic [15:0]           eff_flags;
	logic [17:0]           add_len, sum_wide;
	logic                  bad_index, dup, ok, finish;

	assign eff_total = alloc ? hdr_s1.slice_count : total_q[sel];
	assign eff_recv  = alloc ? 7'd0 : recv_q[sel];
	assign eff_seen  = alloc ? '0 : seen_q[sel];
	assign eff_sum   = alloc ? 17'd0 : sum_q[sel];
	assign eff_time  = alloc ? hdr_s1.timestamp : time_q[sel];
	assign eff_flags = alloc ? hdr_s1.frame_flags : flags_q[sel];

	assign bad_index = ({1'b0, hdr_s1.slice_index} >= eff_total)
		|| ({3'b000, hdr_s1.slice_index} >= 9'(MAX_SLICES));
	assign seen_bit  = MAX_SLICES'(1) << hdr_s1.slice_index;
	assign dup       = |(eff_seen & seen_bit);
	assign ok        = v_s1 && !stale && !no_slot && !bad_index && !dup;

	// Each slice adds at most one slice buffer of bytes; the running sum saturates.
	assign add_len  = (18'(hdr_s1.payload_len) > 18'(SLICE_BYTES))
		? 18'(SLICE_BYTES) : 18'(hdr_s1.payload_len);
	assign sum_wide = 18'(eff_sum) + add_len;
	assign new_sum  = (sum_wide > 18'(SUM_MAX)) ? SUM_MAX : sum_wide[16:0];
	assign new_recv = eff_recv + 7'd1;
	assign finish   = ok && (new_recv == eff_total);

	// Delivery abandons every other pending frame that is not newer than it.
	logic [WINDOW_SLOTS-1:0] abandon;
	logic [DROP_W-1:0]       drop_raw;
	logic [3:0]              drop_sat;

	always_comb begin
		for (int i = 0; i < WINDOW_SLOTS; i++) begin
			abandon[i] = finish && busy_q[i] && (SLOT_W'(i) != sel)
				&& !id_after(frame_q[i], hdr_s1.frame_id);
		end
	end

	assign drop_raw = DROP_W'($countones(abandon)) + DROP_W'(evict && v_s1 && !stale);
	assign drop_sat = (drop_raw > DROP_W'(DROP_MAX)) ? DROP_MAX : 4'(drop_raw);

	// Write offset of the payload in the buffer area, past the areas of the lower slots.
	logic [31:0] offset_wide;

	assign offset_wide = (32'(sel) * 32'(MAX_SLICES) + 32'(hdr_s1.slice_index))
		* 32'(SLICE_BYTES);

	// State update.
	logic wr_en;

	assign wr_en = alloc || ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= '0;
			last_q     <= 32'd0;
			dlv_once_q <= 1'b0;
		end else begin
			for (int i = 0; i < WINDOW_SLOTS; i++) begin
				if (finish && ((SLOT_W'(i) == sel) || abandon[i])) begin
					busy_q[i] <= 1'b0;
				end else if (alloc && (SLOT_W'(i) == sel)) begin
					busy_q[i] <= 1'b1;
				end
			end
			if (finish) begin
				last_q     <= hdr_s1.frame_id;
				dlv_once_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (alloc) begin
				frame_q[sel] <= hdr_s1.frame_id;
				time_q[sel]  <= hdr_s1.timestamp;
				flags_q[sel] <= hdr_s1.frame_flags;
				total_q[sel] <= hdr_s1.slice_count;
			end
			seen_q[sel] <= ok ? (eff_seen | seen_bit) : eff_seen;
			recv_q[sel] <= ok ? new_recv : eff_recv;
			sum_q[sel]  <= ok ? new_sum : eff_sum;
		end
	end

	// Result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s2 <= 1'b0;
		end else begin
			strobe_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			if (stale) begin
				res_s2.status <= ST_STALE;
			end else if (no_slot) begin
				res_s2.status <= ST_NO_SLOT;
			end else if (bad_index) begin
				res_s2.status <= ST_BAD_INDEX;
			end else if (dup) begin
				res_s2.status <= ST_DUPLICATE;
			end else begin
				res_s2.status <= ST_ACCEPTED;
			end
			res_s2.slot           <= ok ? 3'(sel) : 3'd0;
			res_s2.write_offset   <= ok ? offset_wide[18:0] : 19'd0;
			res_s2.complete       <= finish;
			res_s2.done_frame_id  <= finish ? hdr_s1.frame_id : 32'd0;
			res_s2.done_timestamp <= finish ? eff_time : 32'd0;
			res_s2.done_flags     <= finish ? eff_flags : 16'd0;
			res_s2.done_length    <= finish ? new_sum : 17'd0;
			res_s2.dropped_count  <= drop_sat;
		end
	end

	assign strobe = strobe_s2;
	assign res    = res_s2;

	// Checks.
	a_strobe_follows: assert property (@(posedge clk) disable iff (!arst_n)
		strobe == $past(v_s1))
		else $error("result strobe does not follow the accepted header");

	a_complete_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && res.complete) |-> (res.status == ST_ACCEPTED))
		else $error("delivery reported on a dropped slice");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (res.status != ST_ACCEPTED)) |-> (res.slot == 3'd0
			&& res.write_offset == 19'd0 && !res.complete))
		else $error("dropped slice carries slot or offset");

	a_delivery_recorded: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && res.complete) |-> (dlv_once_q && last_q == res.done_frame_id))
		else $error("delivered frame not recorded as last delivered");

	a_stale_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && res.status == ST_STALE) |-> (res.dropped_count == 4'd0))
		else $error("stale slice reported dropped frames");

	a_delivered_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		dlv_once_q |=> dlv_once_q)
		else $error("delivery history lost");

endmodule

@@ tb/sv/tb_video_slice_frame_reassembler.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for video_slice_frame_reassembler: directed slice headers, then
// random frame traffic, each result word checked against an in-bench model of the slot window.
// Depends on vsfr_pkg (header and result word types, status codes, default sizes).
module tb_video_slice_frame_reassembler
	import vsfr_pkg::*;
();

	localparam int WINDOW    = WINDOW_SLOTS_DEF;
	localparam int SLICES    = MAX_SLICES_DEF;
	localparam int BYTES     = SLICE_BYTES_DEF;
	localparam int CYCLE_CAP = 400000;
	localparam int OPEN_MAX  = 4;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	slice_hdr_t hdr = '0;
	logic       strobe;
	slice_res_t res;

	video_slice_frame_reassembler uut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.hdr   (hdr),
		.strobe(strobe),
		.res   (res)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Shadow of the pending frame window. Entries other than the busy flags are only read
	// for busy slots, so their contents after reset do not matter.
	bit          pend_busy  [WINDOW];
	logic [31:0] pend_frame [WINDOW];
	logic [31:0] pend_time  [WINDOW];
	logic [15:0] pend_flags [WINDOW];
	logic [6:0]  pend_total [WINDOW];
	logic [6:0]  pend_got   [WINDOW];
	logic [63:0] pend_seen  [WINDOW];
	logic [16:0] pend_bytes [WINDOW];
	logic [31:0] last_done_id = '0;
	bit          any_done = 1'b0;

	// Result words still owed by the block, oldest first.
	slice_res_t  owed_results[$];

	int          mismatch_count = 0;
	int          headers_sent = 0;
	int          frames_delivered = 0;
	int          status_seen[5] = '{default: 0};
	int          idle_pct = 0;
	slice_res_t  due_word;

	// Random traffic bookkeeping: frames currently being streamed slice by slice.
	bit          open_on   [OPEN_MAX];
	logic [31:0] open_id   [OPEN_MAX];
	logic [6:0]  open_cnt  [OPEN_MAX];
	logic [6:0]  open_left [OPEN_MAX];
	logic [63:0] open_sent [OPEN_MAX];
	logic [31:0] open_ts   [OPEN_MAX];
	logic [15:0] open_fl   [OPEN_MAX];
	logic [31:0] frame_cursor = '0;

	// Frame id a is newer than b when the 32-bit difference is nonzero and positive as signed.
	function automatic bit frame_newer(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] diff;
		diff = a - b;
		return (diff != 32'd0) && !diff[31];
	endfunction

	// Files one header into the shadow window and returns the result word it must produce.
	function automatic slice_res_t file_slice(input slice_hdr_t h);
		slice_res_t  r;
		int          found;
		int          free_s;
		int          oldest;
		int          s;
		logic [3:0]  lost;
		logic [17:0] sum;
		logic [10:0] add;
		r = '0;
		found = -1;
		free_s = -1;
		oldest = -1;
		lost = '0;
		// Anything not newer than the last delivered frame is late and changes nothing.
		if (any_done && !frame_newer(h.frame_id, last_done_id)) begin
			r.status = ST_STALE;
			return r;
		end
		for (int i = 0; i < WINDOW; i++) begin
			if (pend_busy[i] && pend_frame[i] == h.frame_id) begin
				found = i;
				break;
			end
			if (!pend_busy[i] && free_s < 0)
				free_s = i;
			if (pend_busy[i] && (oldest < 0 || frame_newer(pend_frame[oldest], pend_frame[i])))
				oldest = i;
		end
		if (found >= 0) begin
			s = found;
		end else begin
			s = free_s;
			if (s < 0) begin
				// Window full: only a frame newer than the oldest pending one may evict it.
				if (oldest >= 0 && frame_newer(h.frame_id, pend_frame[oldest])) begin
					lost = 4'd1;
					s = oldest;
				end else begin
					r.status = ST_NO_SLOT;
					return r;
				end
			end
			pend_busy[s]  = 1'b1;
			pend_frame[s] = h.frame_id;
			pend_time[s]  = h.timestamp;
			pend_flags[s] = h.frame_flags;
			pend_total[s] = h.slice_count;
			pend_got[s]   = '0;
			pend_seen[s]  = '0;
			pend_bytes[s] = '0;
		end
		r.dropped_count = lost;
		// The allocation and any eviction above stay in effect even when the index is bad.
		if (h.slice_index >= pend_total[s] || h.slice_index >= SLICES) begin
			r.status = ST_BAD_INDEX;
			return r;
		end
		if (pend_seen[s][h.slice_index]) begin
			r.status = ST_DUPLICATE;
			return r;
		end
		pend_seen[s][h.slice_index] = 1'b1;
		pend_got[s] = pend_got[s] + 7'd1;
		add = (h.payload_len > BYTES) ? 11'(BYTES) : h.payload_len;
		sum = pend_bytes[s] + add;
		pend_bytes[s] = (sum > SUM_MAX) ? SUM_MAX : sum[16:0];
		r.status = ST_ACCEPTED;
		r.slot = 3'(s);
		r.write_offset = 19'((s * SLICES + int'(h.slice_index)) * BYTES);
		if (pend_got[s] == pend_total[s]) begin
			r.complete       = 1'b1;
			r.done_frame_id  = pend_frame[s];
			r.done_timestamp = pend_time[s];
			r.done_flags     = pend_flags[s];
			r.done_length    = pend_bytes[s];
			last_done_id     = pend_frame[s];
			any_done         = 1'b1;
			pend_busy[s]     = 1'b0;
			// Delivery abandons every pending frame that is not newer than the delivered one.
			for (int i = 0; i < WINDOW; i++) begin
				if (pend_busy[i] && !frame_newer(pend_frame[i], last_done_id)) begin
					pend_busy[i] = 1'b0;
					if (lost != DROP_MAX)
						lost = lost + 4'd1;
				end
			end
			r.dropped_count = lost;
		end
		return r;
	endfunction

	function automatic slice_hdr_t make_hdr(input logic [31:0] id, input int idx, input int cnt,
			input int len, input logic [31:0] ts, input logic [15:0] fl);
		slice_hdr_t h;
		h.frame_id    = id;
		h.slice_index = 6'(idx);
		h.slice_count = 7'(cnt);
		h.payload_len = 11'(len);
		h.timestamp   = ts;
		h.frame_flags = fl;
		return h;
	endfunction

	// Presents one header, waits for the block to take it, records the word it owes, then
	// leaves start high for a back-to-back header or drops it for a random gap.
	task automatic send_slice(input slice_hdr_t h);
		int gap;
		gap = 0;
		start <= 1'b1;
		hdr   <= h;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		owed_results.push_back(file_slice(h));
		headers_sent++;
		while (gap < 30 && $urandom_range(99, 0) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// Every strobe is matched against the oldest owed word. The block cannot be held off, so
	// outputs are sampled at each rising edge, before the block's own updates land.
	always @(posedge clk) begin
		if (arst_n && strobe === 1'b1) begin
			if (owed_results.size() == 0) begin
				$error("result word with nothing expected: status %0d", res.status);
				mismatch_count++;
			end else begin
				due_word = owed_results.pop_front();
				check_field("status", due_word.status, res.status);
				check_field("slot", due_word.slot, res.slot);
				check_field("write_offset", due_word.write_offset, res.write_offset);
				check_field("complete", due_word.complete, res.complete);
				check_field("done_frame_id", due_word.done_frame_id, res.done_frame_id);
				check_field("done_timestamp", due_word.done_timestamp, res.done_timestamp);
				check_field("done_flags", due_word.done_flags, res.done_flags);
				check_field("done_length", due_word.done_length, res.done_length);
				check_field("dropped_count", due_word.dropped_count, res.dropped_count);
				if (due_word.status <= ST_DUPLICATE)
					status_seen[int'(due_word.status)]++;
				if (due_word.complete)
					frames_delivered++;
			end
		end
	end

	// Frame 0 may be taken before anything was delivered; after that, equal ids and ids up to
	// half the number space behind the last delivered one are late.
	task automatic test_stale_and_wrap();
		send_slice(make_hdr(32'h0000_0000, 0, 1, BYTES, 32'hFFFF_FFFF, 16'hFFFF));
		send_slice(make_hdr(32'h0000_0000, 0, 1, 5, 32'h1, 16'h1));
		send_slice(make_hdr(32'hFFFF_FFFF, 0, 1, 5, 32'h2, 16'h2));
		send_slice(make_hdr(32'h8000_0000, 0, 1, 5, 32'h3, 16'h3));
	endtask

	// A zero slice count, a count above the index range, the top index, an oversized payload,
	// a repeated slice and an index past the stored count; the last frame then completes and
	// abandons the three older ones still pending.
	task automatic test_bad_index_and_duplicate();
		send_slice(make_hdr(32'd5, 0, 0, 0, 32'h0, 16'h0));
		send_slice(make_hdr(32'd6, 63, 127, 2047, 32'h6, 16'h6));
		send_slice(make_hdr(32'd7, 63, 64, 2047, 32'h7, 16'h7));
		send_slice(make_hdr(32'd7, 63, 64, 100, 32'h7, 16'h7));
		send_slice(make_hdr(32'd8, 5, 3, 100, 32'hA5A5_5A5A, 16'h8001));
		send_slice(make_hdr(32'd8, 0, 3, 10, 32'h0, 16'h0));
		send_slice(make_hdr(32'd8, 1, 3, 1024, 32'h0, 16'h0));
		send_slice(make_hdr(32'd8, 2, 3, 0, 32'h0, 16'h0));
	endtask

	// Fill all eight slots, refuse a frame older than the oldest pending one, then evict with
	// a newer single-slice frame whose delivery abandons the other seven.
	task automatic test_window_full();
		for (int k = 0; k < WINDOW; k++)
			send_slice(make_hdr(32'(20 + k), 0, 2, 64 * k, 32'(k), 16'(k)));
		send_slice(make_hdr(32'd19, 0, 2, 1, 32'h19, 16'h19));
		send_slice(make_hdr(32'd30, 0, 1, 512, 32'h30, 16'h30));
		send_slice(make_hdr(32'd31, 0, 1, 0, 32'h31, 16'h31));
	endtask

	// Mostly well-formed frames streamed with their slices shuffled and up to four frames
	// interleaved, plus repeated slices and fully random headers as noise.
	task automatic test_random_traffic(input int count);
		slice_hdr_t h;
		int         roll;
		int         live;
		int         j;
		int         idx;
		for (int n = 0; n < count; n++) begin
			// Frames that fell behind the last delivery would only produce late words.
			for (int k = 0; k < OPEN_MAX; k++)
				if (open_on[k] && any_done && !frame_newer(open_id[k], last_done_id))
					open_on[k] = 1'b0;
			roll = $urandom_range(99, 0);
			h.timestamp   = $urandom;
			h.frame_flags = 16'($urandom_range(16'hFFFF, 0));
			h.payload_len = ($urandom_range(9, 0) == 0) ? 11'($urandom_range(2047, 1025))
				: 11'($urandom_range(BYTES, 0));
			if (roll < 12) begin
				h.frame_id = ($urandom_range(3, 0) == 0) ? $urandom
					: frame_cursor - 32'd4 + 32'($urandom_range(8, 0));
				h.slice_index = 6'($urandom_range(63, 0));
				h.slice_count = 7'($urandom_range(127, 0));
				h.payload_len = 11'($urandom_range(2047, 0));
			end else begin
				live = 0;
				for (int k = 0; k < OPEN_MAX; k++)
					live += open_on[k];
				if (live == 0 || (live < OPEN_MAX && $urandom_range(99, 0) < 22)) begin
					j = 0;
					while (open_on[j])
						j++;
					// A random header may have delivered a far-ahead frame; catch up to it.
					if (any_done && !frame_newer(frame_cursor + 32'd1, last_done_id))
						frame_cursor = last_done_id;
					frame_cursor += ($urandom_range(39, 0) == 0)
						? 32'($urandom_range(32'h3FFF_FFFF, 1)) : 32'($urandom_range(3, 1));
					open_on[j]   = 1'b1;
					open_id[j]   = frame_cursor;
					open_cnt[j]  = ($urandom_range(19, 0) == 0) ? 7'($urandom_range(SLICES, 9))
						: 7'($urandom_range(8, 1));
					open_left[j] = open_cnt[j];
					open_sent[j] = '0;
					open_ts[j]   = $urandom;
					open_fl[j]   = 16'($urandom_range(16'hFFFF, 0));
				end
				do
					j = $urandom_range(OPEN_MAX - 1, 0);
				while (!open_on[j]);
				h.frame_id    = open_id[j];
				h.slice_count = open_cnt[j];
				h.timestamp   = open_ts[j];
				h.frame_flags = open_fl[j];
				if (roll < 17 && open_sent[j] != '0) begin
					do
						idx = $urandom_range(63, 0);
					while (!open_sent[j][idx]);
				end else begin
					do
						idx = $urandom_range(int'(open_cnt[j]) - 1, 0);
					while (open_sent[j][idx]);
					open_sent[j][idx] = 1'b1;
					open_left[j] = open_left[j] - 7'd1;
					if (open_left[j] == '0)
						open_on[j] = 1'b0;
				end
				h.slice_index = 6'(idx);
			end
			send_slice(h);
		end
	endtask

	// Watchdog: a hung handshake or a missing result word ends the run here.
	initial begin
		repeat (CYCLE_CAP) @(posedge clk);
		$display("video_slice_frame_reassembler test failed");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 11;
		test_stale_and_wrap();
		test_bad_index_and_duplicate();
		test_window_full();
		// Sender gaps: light, then heavy, then none at all.
		test_random_traffic(510);
		idle_pct = 72;
		test_random_traffic(510);
		idle_pct = 0;
		test_random_traffic(505);
		start <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		// Give the pipeline room to show any stray word.
		repeat (8) @(posedge clk);
		$display("Covered %0d slice headers: %0d accepted, %0d late, %0d without a slot, %0d %s",
			headers_sent, status_seen[ST_ACCEPTED], status_seen[ST_STALE],
			status_seen[ST_NO_SLOT], status_seen[ST_BAD_INDEX], "with a bad index,");
		$display("%0d repeated slices and %0d frames delivered, under light, heavy and no gaps.",
			status_seen[ST_DUPLICATE], frames_delivered);
		if (mismatch_count == 0)
			$display("video_slice_frame_reassembler test passed");
		else
			$display("video_slice_frame_reassembler test failed");
		$finish;
	end

endmodule
